// File: design/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// Types, constants and the Morse code table shared by the character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int GLYPH_LEN = 14;   // longest code in the table, in elements
  localparam int GLYPH_CNT = 67;   // entries in the code table
  localparam int ADDR_W    = 7;
  localparam int LEN_W     = 4;
  localparam int POS_W     = 4;
  localparam int DOT_W     = 16;
  localparam int DUR_W     = 19;
  localparam int CHAR_W    = 8;

  localparam logic [15:0]     DOT_RESET  = 16'd1000;
  localparam logic [CHAR_W-1:0] CHAR_BASE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_FOLD  = 8'h40;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h60;

  typedef enum logic [1:0] {
    EL_NONE,
    EL_DOT,
    EL_DASH,
    EL_GAP
  } elem_t;

  // Element 0 is the last one sent; the sequencer walks down from len-1.
  typedef struct packed {
    logic [LEN_W-1:0]                len;
    logic [GLYPH_LEN-1:0][1:0]       el;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  // Turn a right-justified code string into an entry.
  function automatic glyph_t glyph_enc(input logic [8*GLYPH_LEN-1:0] s);
    glyph_t     g;
    logic [7:0] b;
    elem_t      e;
    g = '0;
    for (int i = 0; i < GLYPH_LEN; i++) begin
      b = s[8*i +: 8];
      if (b == 8'h2E)      e = EL_DOT;
      else if (b == 8'h2D) e = EL_DASH;
      else if (b == 8'h20) e = EL_GAP;
      else                 e = EL_NONE;
      g.el[i] = e;
      if (e != EL_NONE) g.len = g.len + LEN_W'(1);
    end
    return g;
  endfunction

  function automatic glyph_t glyph_rom(input logic [ADDR_W-1:0] idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = glyph_enc(" ");
      7'd1:  g = glyph_enc("--..--");
      7'd2:  g = glyph_enc(".-..-.");
      7'd3:  g = glyph_enc("-. ---");
      7'd4:  g = glyph_enc("..- ... --.");
      7'd5:  g = glyph_enc(".--. -.-.");
      7'd6:  g = glyph_enc(".- -. -..");
      7'd7:  g = glyph_enc(".----.");
      7'd8:  g = glyph_enc("-.--.-");
      7'd9:  g = glyph_enc("-.--.-");
      7'd10: g = glyph_enc("... - .-.");
      7'd11: g = glyph_enc(".--. .-.. ...");
      7'd12: g = glyph_enc(".-.-.-");
      7'd13: g = glyph_enc("-....-");
      7'd14: g = glyph_enc("......");
      7'd15: g = glyph_enc("-..-.");
      7'd16: g = glyph_enc("-----");
      7'd17: g = glyph_enc(".----");
      7'd18: g = glyph_enc("..---");
      7'd19: g = glyph_enc("...--");
      7'd20: g = glyph_enc(".....");
      7'd21: g = glyph_enc("....-");
      7'd22: g = glyph_enc("-....");
      7'd23: g = glyph_enc("--...");
      7'd24: g = glyph_enc("---..");
      7'd25: g = glyph_enc("----.");
      7'd26: g = glyph_enc("---...");
      7'd27: g = glyph_enc("-.-.-.");
      7'd28: g = glyph_enc(".-..");
      7'd29: g = glyph_enc(". --.-");
      7'd30: g = glyph_enc("--. -");
      7'd31: g = glyph_enc("..--..");
      7'd32: g = glyph_enc(".--.-.");
      7'd33: g = glyph_enc(".-");
      7'd34: g = glyph_enc("-...");
      7'd35: g = glyph_enc("-.-.");
      7'd36: g = glyph_enc("-..");
      7'd37: g = glyph_enc(".");
      7'd38: g = glyph_enc("..-.");
      7'd39: g = glyph_enc("--.");
      7'd40: g = glyph_enc("....");
      7'd41: g = glyph_enc("..");
      7'd42: g = glyph_enc(".---");
      7'd43: g = glyph_enc("-.-");
      7'd44: g = glyph_enc(".-..");
      7'd45: g = glyph_enc("--");
      7'd46: g = glyph_enc("-.");
      7'd47: g = glyph_enc("---");
      7'd48: g = glyph_enc(".--.");
      7'd49: g = glyph_enc("--.-");
      7'd50: g = glyph_enc(".-.");
      7'd51: g = glyph_enc("...");
      7'd52: g = glyph_enc("-");
      7'd53: g = glyph_enc("..-");
      7'd54: g = glyph_enc("...-");
      7'd55: g = glyph_enc(".--");
      7'd56: g = glyph_enc("-..-");
      7'd57: g = glyph_enc("-.--");
      7'd58: g = glyph_enc("--..");
      7'd59: g = glyph_enc("-.--.-");
      7'd60: g = glyph_enc("-..-.");
      7'd61: g = glyph_enc("-.--.-");
      7'd62: g = glyph_enc("-.-. ..-. -..-");
      7'd63: g = glyph_enc("-....-");
      7'd64: g = glyph_enc(".----.");
      7'd65: g = glyph_enc("-....-");
      7'd66: g = glyph_enc("........");
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: design/mck_ram.sv
// ----------------------------------------------------------------------------
// mck_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns one ASCII character into its Morse keying as (level, duration) words.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  input    in_character                            start & !busy
//  result   out_key_level, out_duration_ticks,      out_valid, one cycle each
//           out_last, out_bad_symbol
//  config   cfg_dot_ticks                           cfg_we, no wait
//
//  After accept a character runs through load, an on and an off period per
//  code element and the closing gap; one without a table entry goes straight
//  to the closing gap. The sequencer sends one period per cycle from the
//  entry read out of the RAM. After reset the code table is copied into the
//  RAM, busy high. The receiver cannot stall; every word is shown for one cycle.
// ----------------------------------------------------------------------------
module morse_character_keyer
  import mck_pkg::*;
#(
  parameter int MAX_CODE_ELEMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CHAR_W-1:0] in_character,
  output logic              out_valid,
  output logic              out_key_level,
  output logic [DUR_W-1:0]  out_duration_ticks,
  output logic              out_last,
  output logic              out_bad_symbol,
  input  logic              cfg_we,
  input  logic [DOT_W-1:0]  cfg_dot_ticks
);

  localparam int CNT_W = (MAX_CODE_ELEMENTS > 1) ? $clog2(MAX_CODE_ELEMENTS) : 1;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_LOAD,
    ST_ON,
    ST_OFF,
    ST_END
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic [DOT_W-1:0]  dot_r;
  glyph_t            entry_r, entry_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bad_r, bad_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_level_r, out_level_nxt;
  logic [DUR_W-1:0]  out_dur_r, out_dur_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic              accept;
  logic              char_ok;
  logic [ADDR_W-1:0] char_idx;
  logic [GLYPH_W-1:0] ram_wdata;
  logic [GLYPH_W-1:0] ram_rdata;
  glyph_t            ram_glyph;
  elem_t             el_cur;
  logic [DUR_W-1:0]  dur_1, dur_2, dur_3, dur_6;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Printable range 0x20..0x7F; lower case folds onto the upper-case entries.
  assign char_ok  = !in_character[7] && (in_character[6:5] != 2'b00);
  assign char_idx = (in_character > CHAR_UPPER) ? ADDR_W'(in_character - CHAR_FOLD)
                                                : ADDR_W'(in_character - CHAR_BASE);

  assign ram_wdata = GLYPH_W'(glyph_rom(fill_r));
  assign ram_glyph = glyph_t'(ram_rdata);

  mck_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_CNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (state_r == ST_FILL),
    .waddr (fill_r),
    .wdata (ram_wdata),
    .raddr (char_idx),
    .rdata (ram_rdata)
  );

  assign dur_1 = {3'b000, dot_r};
  assign dur_2 = {2'b00, dot_r, 1'b0};
  assign dur_3 = dur_1 + dur_2;
  assign dur_6 = {dur_3[DUR_W-2:0], 1'b0};

  assign el_cur = elem_t'(entry_r.el[pos_r]);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    entry_nxt     = entry_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    out_valid_nxt = 1'b0;
    out_level_nxt = out_level_r;
    out_dur_nxt   = out_dur_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;

    unique case (state_r)
      ST_FILL: begin
        fill_nxt = fill_r + ADDR_W'(1);
        if (fill_r == ADDR_W'(GLYPH_CNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          bad_nxt   = !char_ok;
          state_nxt = char_ok ? ST_LOAD : ST_END;
        end
      end
      ST_LOAD: begin
        entry_nxt = ram_glyph;
        pos_nxt   = ram_glyph.len - LEN_W'(1);
        cnt_nxt   = '0;
        state_nxt = (ram_glyph.len == '0) ? ST_END : ST_ON;
      end
      ST_ON: begin
        out_valid_nxt = 1'b1;
        out_level_nxt = (el_cur != EL_GAP);
        out_last_nxt  = 1'b0;
        out_bad_nxt   = 1'b0;
        unique case (el_cur)
          EL_DASH: out_dur_nxt = dur_3;
          EL_GAP:  out_dur_nxt = dur_6;
          default: out_dur_nxt = dur_1;
        endcase
        state_nxt = ST_OFF;
      end
      ST_OFF: begin
        out_valid_nxt = 1'b1;
        out_level_nxt = 1'b0;
        out_dur_nxt   = dur_1;
        out_last_nxt  = 1'b0;
        out_bad_nxt   = 1'b0;
        // drop whatever lies past the element limit
        if (pos_r == '0 || cnt_r == CNT_W'(MAX_CODE_ELEMENTS - 1)) begin
          state_nxt = ST_END;
        end else begin
          pos_nxt   = pos_r - POS_W'(1);
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_ON;
        end
      end
      ST_END: begin
        out_valid_nxt = 1'b1;
        out_level_nxt = 1'b0;
        out_dur_nxt   = dur_2;
        out_last_nxt  = 1'b1;
        out_bad_nxt   = bad_r;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_r      <= '0;
      dot_r       <= DOT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        dot_r <= cfg_dot_ticks;
      end
    end
    entry_r     <= entry_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    bad_r       <= bad_nxt;
    out_level_r <= out_level_nxt;
    out_dur_r   <= out_dur_nxt;
    out_last_r  <= out_last_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_key_level      = out_level_r;
  assign out_duration_ticks = out_dur_r;
  assign out_last           = out_last_r;
  assign out_bad_symbol     = out_bad_r;

  // The closing gap hands the block back to idle in the same cycle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == ST_IDLE))
    else $error("last word shown while sequencer still running");

  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_last_r && !out_level_r))
    else $error("bad symbol flag outside closing gap");

  a_no_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !out_valid_r)
    else $error("word sent during table load");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted character did not raise busy");

  a_key_off_after_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_level_r) |=> (out_valid_r && !out_level_r && !out_last_r))
    else $error("key-on period not followed by one-dot gap");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Morse character keyer. Characters are pushed in
// with random gaps, and every keying word that comes out is compared with a
// prediction built from a private copy of the code table and dot length.
// ----------------------------------------------------------------------------

typedef struct {
  logic                     key_level;
  logic [mck_pkg::DUR_W-1:0] duration;
  logic                     last;
  logic                     bad_symbol;
} keying_word_t;

class keying_ledger;
  localparam int  ELEM_LIMIT = 16;
  localparam byte MARK_DOT   = 8'h2E;
  localparam byte MARK_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_TOP = 8'h7F;

  int unsigned  dot_len;
  keying_word_t pending_words[$];
  string        codes[mck_pkg::GLYPH_CNT];
  int           chars_sent;
  int           words_seen;
  int           errors;

  function new();
    dot_len = 32'(mck_pkg::DOT_RESET);
    codes = '{
      " ", "--..--", ".-..-.", "-. ---", "..- ... --.", ".--. -.-.",
      ".- -. -..", ".----.", "-.--.-", "-.--.-", "... - .-.", ".--. .-.. ...",
      ".-.-.-", "-....-", "......", "-..-.", "-----", ".----", "..---",
      "...--", ".....", "....-", "-....", "--...", "---..", "----.",
      "---...", "-.-.-.", ".-..", ". --.-", "--. -", "..--..", ".--.-.",
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..", "-.--.-",
      "-..-.", "-.--.-", "-.-. ..-. -..-", "-....-", ".----.", "-....-",
      "........"
    };
    chars_sent = 0;
    words_seen = 0;
    errors     = 0;
  endfunction

  function void set_dot(logic [mck_pkg::DOT_W-1:0] v);
    dot_len = 32'(v);
  endfunction

  function int pending();
    return pending_words.size();
  endfunction

  function void push_word(bit key, int unsigned dots, bit fin, bit bad);
    keying_word_t w;
    w.key_level  = key;
    w.duration   = mck_pkg::DUR_W'(dots * dot_len);
    w.last       = fin;
    w.bad_symbol = bad;
    pending_words.push_back(w);
  endfunction

  // Expand one accepted character into its keying words.
  function void note_character(logic [7:0] c);
    int    idx;
    string s;
    chars_sent++;
    if (c < mck_pkg::CHAR_BASE || c > CHAR_TOP) begin
      push_word(1'b0, 2, 1'b1, 1'b1);
      return;
    end
    // fold lower case onto the upper-case entries
    idx = (c > mck_pkg::CHAR_UPPER) ? int'(c - mck_pkg::CHAR_FOLD)
                                    : int'(c - mck_pkg::CHAR_BASE);
    s = codes[idx];
    for (int n = 0; n < ELEM_LIMIT && n < s.len(); n++) begin
      if (s[n] == MARK_DOT)       push_word(1'b1, 1, 1'b0, 1'b0);
      else if (s[n] == MARK_DASH) push_word(1'b1, 3, 1'b0, 1'b0);
      else                        push_word(1'b0, 6, 1'b0, 1'b0);
      push_word(1'b0, 1, 1'b0, 1'b0);
    end
    push_word(1'b0, 2, 1'b1, 1'b0);
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_word(keying_word_t got);
    keying_word_t want;
    words_seen++;
    if (pending_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, got level %0d dur %0d last %0d bad %0d",
               $time, got.key_level, got.duration, got.last, got.bad_symbol);
      return;
    end
    want = pending_words.pop_front();
    compare("key_level", 32'(want.key_level), 32'(got.key_level));
    compare("duration_ticks", 32'(want.duration), 32'(got.duration));
    compare("last", 32'(want.last), 32'(got.last));
    compare("bad_symbol", 32'(want.bad_symbol), 32'(got.bad_symbol));
  endfunction
endclass

module tb;
  import mck_pkg::*;

  localparam int MAX_ELEMS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CHAR_W-1:0] in_character;
  logic              out_valid;
  logic              out_key_level;
  logic [DUR_W-1:0]  out_duration_ticks;
  logic              out_last;
  logic              out_bad_symbol;
  logic              cfg_we;
  logic [DOT_W-1:0]  cfg_dot_ticks;

  keying_ledger ledger = new();
  int           cycles = 0;
  bit           no_gap_run = 0;

  morse_character_keyer #(
    .MAX_CODE_ELEMENTS(MAX_ELEMS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_character      (in_character),
    .out_valid         (out_valid),
    .out_key_level     (out_key_level),
    .out_duration_ticks(out_duration_ticks),
    .out_last          (out_last),
    .out_bad_symbol    (out_bad_symbol),
    .cfg_we            (cfg_we),
    .cfg_dot_ticks     (cfg_dot_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Track accepted characters, register writes and outgoing words.
  always @(posedge clk) begin
    keying_word_t w;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (cfg_we) ledger.set_dot(cfg_dot_ticks);
      if (start && !busy) ledger.note_character(in_character);
      if (out_valid) begin
        w.key_level  = out_key_level;
        w.duration   = out_duration_ticks;
        w.last       = out_last;
        w.bad_symbol = out_bad_symbol;
        ledger.check_word(w);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, ledger.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    // switch between bursts with no gaps and randomly spaced characters
    if ($urandom_range(0, 7) == 0) no_gap_run = !no_gap_run;
    gap = no_gap_run ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      start        = 1'b0;
      in_character = 8'($urandom);
    end
    @(negedge clk);
    start        = 1'b1;
    in_character = c;
    do @(posedge clk); while (busy);
  endtask

  task automatic release_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_dot(input logic [DOT_W-1:0] v);
    release_start();
    wait_drained();
    @(negedge clk);
    cfg_we        = 1'b1;
    cfg_dot_ticks = v;
    @(negedge clk);
    cfg_we        = 1'b0;
  endtask

  // Mostly printable characters, with some out-of-table codes as noise.
  task automatic run_random(input int count);
    logic [7:0] c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) != 0) c = 8'($urandom_range(8'h20, 8'h7F));
      else                           c = 8'($urandom);
      send_char(c);
    end
  endtask

  initial begin
    logic [7:0]       directed[];
    logic [DOT_W-1:0] mid_dot;
    directed = '{
      8'h00, 8'hFF, 8'h1F, 8'h80, 8'h20, 8'h7F, 8'h60, 8'h61, 8'h41,
      8'h7E, 8'h5E, 8'h5F, 8'h30, 8'h39, 8'h45, 8'h48, 8'h2C, 8'h55,
      8'hAA, 8'h3F, 8'h40, 8'h24
    };
    rst_n         = 1'b0;
    start         = 1'b0;
    in_character  = '0;
    cfg_we        = 1'b0;
    cfg_dot_ticks = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset dot length first, then table extremes and out-of-range codes
    foreach (directed[i]) send_char(directed[i]);

    write_dot(16'd1);
    send_char(8'h7E);
    run_random(55);

    write_dot(16'hFFFF);
    send_char(8'h20);
    send_char(8'h7E);
    run_random(55);

    // zero dot length is out of range but still used as written
    write_dot(16'd0);
    run_random(40);

    mid_dot = 16'($urandom_range(2, 65534));
    write_dot(mid_dot);
    run_random(55);

    write_dot(DOT_RESET);
    run_random(55);

    release_start();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d characters and checked %0d keying words", ledger.chars_sent,
             ledger.words_seen);
    $display("Dot lengths used: 1000, 1, 65535, 0, %0d and 1000 again", mid_dot);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words never seen", ledger.errors, ledger.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
